[hw/rtl/vrtc_pkg.sv]
// shared types and constants for the virtual rtc channel bank
`timescale 1ns / 1ps
package vrtc_pkg;

  localparam int FUNC_W   = 3;
  localparam int CH_W     = 3;
  localparam int RATE_W   = 13;
  localparam int BYTES_W  = 4;
  localparam int MASK_W   = 8;
  localparam int RELOAD_W = 10;
  localparam logic [RELOAD_W-1:0] RELOAD_MAX = 10'd1023;
  localparam int QDEPTH   = 2;

  localparam logic [FUNC_W-1:0] FN_TICK  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_OPEN  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_WRITE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_READ  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLOSE = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [CH_W-1:0]    channel;
    logic [RATE_W-1:0]  rate_value;
    logic [BYTES_W-1:0] byte_count;
  } in_req_t;

  typedef struct packed {
    logic [MASK_W-1:0] fired_mask;
    logic              any_fired;
    logic              must_wait;
    logic              error;
    logic              irq_on;
  } out_res_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_TICK,
    OP_OPEN,
    OP_WRITE,
    OP_REJECT,
    OP_READ,
    OP_CLOSE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CH_W-1:0]   channel;
    logic [RATE_W-1:0] rate;
    logic              ch_ok;
  } cmd_t;

  typedef enum logic {
    B_IDLE,
    B_DIV
  } back_state_t;

endpackage

[hw/rtl/vrtc_front.sv]
// request decode: turns a raw request into a classified command
`timescale 1ns / 1ps
module vrtc_front #(
  parameter int CHANNELS = 8
) (
  input  vrtc_pkg::in_req_t req,
  output vrtc_pkg::cmd_t    cmd
);
  import vrtc_pkg::*;

  logic ch_ok;

  assign ch_ok = (32'(req.channel) < CHANNELS);

  always_comb begin
    cmd.channel = req.channel;
    cmd.rate    = req.rate_value;
    cmd.ch_ok   = ch_ok;
    case (req.func)
      FN_TICK: begin
        cmd.op = OP_TICK;
      end
      FN_OPEN: begin
        cmd.op = OP_OPEN;
      end
      FN_WRITE: begin
        if (req.byte_count == '0 || req.rate_value == '0) begin
          cmd.op = OP_REJECT;
        end else if (ch_ok) begin
          cmd.op = OP_WRITE;
        end else begin
          cmd.op = OP_NOP;
        end
      end
      FN_READ: begin
        cmd.op = ch_ok ? OP_READ : OP_NOP;
      end
      // close re-evaluates irq even for a channel out of range
      FN_CLOSE: begin
        cmd.op = OP_CLOSE;
      end
      default: begin
        cmd.op = OP_NOP;
      end
    endcase
  end

endmodule

[hw/rtl/vrtc_queue.sv]
// short command queue between decode and execution
`timescale 1ns / 1ps
module vrtc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  vrtc_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           rd_en,
  output vrtc_pkg::cmd_t rd_cmd,
  output logic           empty
);
  import vrtc_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int NW = $clog2(QDEPTH + 1);

  cmd_t          mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full   = (cnt_r == NW'(QDEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_cmd = mem_r[rd_ptr_r];
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

[hw/rtl/vrtc_div.sv]
// restoring divider: base rate over requested rate, one quotient bit a cycle
`timescale 1ns / 1ps
module vrtc_div #(
  parameter int BASE_RATE = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [vrtc_pkg::RATE_W-1:0]         divisor,
  output logic                                done,
  output logic [$clog2(BASE_RATE + 1)-1:0]    quotient
);
  import vrtc_pkg::*;

  localparam int QW   = $clog2(BASE_RATE + 1);
  localparam int CNTW = $clog2(QW);
  localparam logic [QW-1:0] DIVIDEND = QW'(BASE_RATE);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNTW-1:0]   cnt_r, cnt_nxt;
  logic [RATE_W-1:0] rem_r, rem_nxt;
  logic [RATE_W-1:0] dsr_r, dsr_nxt;
  logic [QW-1:0]     quo_r, quo_nxt;
  logic [RATE_W:0]   rem_sh, rem_sub;
  logic              ge;

  assign rem_sh  = {rem_r, DIVIDEND[cnt_r]};
  assign ge      = (rem_sh >= {1'b0, dsr_r});
  assign rem_sub = rem_sh - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNTW'(QW - 1);
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      quo_nxt  = '0;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the top bit drops out
      rem_nxt = ge ? rem_sub[RATE_W-1:0] : rem_sh[RATE_W-1:0];
      quo_nxt = {quo_r[QW-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[hw/rtl/vrtc_back.sv]
// command execution: channel state, tick lanes, rate divider and result slot
`timescale 1ns / 1ps
module vrtc_back #(
  parameter int CHANNELS  = 8,
  parameter int BASE_RATE = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  vrtc_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output vrtc_pkg::out_res_t  res
);
  import vrtc_pkg::*;

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int QW = $clog2(BASE_RATE + 1);
  localparam int SW = (QW > RELOAD_W) ? QW : RELOAD_W;

  back_state_t         state_r, state_nxt;
  logic [CHANNELS-1:0] en_r, en_nxt;
  logic [RELOAD_W-1:0] reload_r [CHANNELS];
  logic [RELOAD_W-1:0] reload_nxt [CHANNELS];
  logic [RELOAD_W-1:0] count_r [CHANNELS];
  logic [RELOAD_W-1:0] count_nxt [CHANNELS];
  logic                irq_r, irq_nxt;
  logic                res_valid_r, res_valid_nxt;
  out_res_t            res_r, res_nxt;
  logic [CW-1:0]       widx_r, widx_nxt;

  logic                slot_free;
  logic                res_load;
  logic [CW-1:0]       idx;
  logic [CHANNELS-1:0] fire;
  logic [RELOAD_W:0]   inc_w;
  logic                div_start;
  logic                div_done;
  logic [QW-1:0]       quotient;
  logic [QW-1:0]       qm1;
  logic [SW-1:0]       qm1_w;
  logic [RELOAD_W-1:0] new_reload;

  vrtc_div #(
    .BASE_RATE(BASE_RATE)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (q_cmd.rate),
    .done    (div_done),
    .quotient(quotient)
  );

  assign slot_free = !res_valid_r || pop;
  assign idx       = CW'(q_cmd.channel);

  // reload = quotient - 1, floored at zero and saturated to the field
  assign qm1   = quotient - QW'(1);
  assign qm1_w = SW'(qm1);
  always_comb begin
    if (quotient == '0) begin
      new_reload = '0;
    end else if (qm1_w > SW'(RELOAD_MAX)) begin
      new_reload = RELOAD_MAX;
    end else begin
      new_reload = RELOAD_W'(qm1_w);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    en_nxt     = en_r;
    reload_nxt = reload_r;
    count_nxt  = count_r;
    irq_nxt    = irq_r;
    widx_nxt   = widx_r;
    res_nxt    = '0;
    res_load   = 1'b0;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    fire       = '0;
    inc_w      = '0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty && slot_free) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            OP_TICK: begin
              res_load = 1'b1;
              for (int i = 0; i < CHANNELS; i++) begin
                inc_w = {1'b0, count_r[i]} + (RELOAD_W + 1)'(1);
                if (en_r[i]) begin
                  if (inc_w >= {1'b0, reload_r[i]}) begin
                    count_nxt[i] = '0;
                    fire[i]      = 1'b1;
                  end else begin
                    count_nxt[i] = inc_w[RELOAD_W-1:0];
                  end
                end
              end
              res_nxt.any_fired = |fire;
            end
            OP_OPEN: begin
              res_load = 1'b1;
              irq_nxt  = 1'b1;
            end
            OP_WRITE: begin
              div_start = 1'b1;
              widx_nxt  = idx;
              state_nxt = B_DIV;
            end
            OP_REJECT: begin
              res_load      = 1'b1;
              res_nxt.error = 1'b1;
            end
            OP_READ: begin
              res_load          = 1'b1;
              res_nxt.must_wait = en_r[idx] && (count_r[idx] < reload_r[idx]);
            end
            OP_CLOSE: begin
              res_load = 1'b1;
              if (q_cmd.ch_ok) begin
                en_nxt[idx] = 1'b0;
              end
              // checked after the channel is cleared
              if (en_nxt == '0) begin
                irq_nxt = 1'b0;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      B_DIV: begin
        if (div_done) begin
          reload_nxt[widx_r] = new_reload;
          count_nxt[widx_r]  = '0;
          en_nxt[widx_r]     = 1'b1;
          res_load           = 1'b1;
          state_nxt          = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
    res_nxt.fired_mask = '0;
    for (int j = 0; j < MASK_W; j++) begin
      if (j < CHANNELS) begin
        res_nxt.fired_mask[j] = fire[j % CHANNELS];
      end
    end
    res_nxt.irq_on = irq_nxt;

    if (res_load) begin
      res_valid_nxt = 1'b1;
    end else if (pop) begin
      res_valid_nxt = 1'b0;
    end else begin
      res_valid_nxt = res_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      en_r        <= '0;
      irq_r       <= 1'b0;
      res_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        reload_r[i] <= '0;
        count_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      en_r        <= en_nxt;
      irq_r       <= irq_nxt;
      res_valid_r <= res_valid_nxt;
      reload_r    <= reload_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    widx_r <= widx_nxt;
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  assign empty = !res_valid_r;
  assign res   = res_r;

  a_div_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> !res_valid_r)
    else $error("result slot busy while a rate write is in the divider");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == B_DIV))
    else $error("divider finished outside a rate write");

  a_write_enables: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV && div_done) |=> en_r[widx_r])
    else $error("channel not enabled after rate write");

  a_pop_guard: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!q_empty && slot_free))
    else $error("command taken without room for its result");

endmodule

[hw/rtl/virtual_rtc_channel_bank.sv]
// top level of the virtual rtc channel bank
//
// channel   ports                        direction  accepted when
// request   push, full, in_item          in         push && !full
// result    empty, pop, out_item         out        pop && !empty
//
// tick, open, read, close and rejected writes finish in the execute stage itself.
// a rate write waits in the execute stage for the bit-serial division of the base
// rate by the requested rate, then loads and enables the channel.
// an accepted request is held in the command queue before execution; two may queue.
// reset is synchronous and clears all channels, the irq bit, queue and result slot.
// a waiting result does not block acceptance until the command queue fills.
`timescale 1ns / 1ps
module virtual_rtc_channel_bank #(
  parameter int CHANNELS  = 8,
  parameter int BASE_RATE = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  vrtc_pkg::in_req_t  in_item,
  output logic               empty,
  input  logic               pop,
  output vrtc_pkg::out_res_t out_item
);
  import vrtc_pkg::*;

  cmd_t front_cmd;
  cmd_t q_cmd;
  logic q_empty;
  logic q_pop;

  vrtc_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .req(in_item),
    .cmd(front_cmd)
  );

  vrtc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (push),
    .wr_cmd(front_cmd),
    .full  (full),
    .rd_en (q_pop),
    .rd_cmd(q_cmd),
    .empty (q_empty)
  );

  vrtc_back #(
    .CHANNELS (CHANNELS),
    .BASE_RATE(BASE_RATE)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_empty(q_empty),
    .q_cmd  (q_cmd),
    .q_pop  (q_pop),
    .empty  (empty),
    .pop    (pop),
    .res    (out_item)
  );

endmodule
